// ===== design/itp_pkg.sv =====
// Shared types, constants and character helpers for the infix-to-prefix converter.
// No dependencies; the converter, front, queue and back modules import this package.
package itp_pkg;

  localparam int MaxLenDef = 64;
  localparam int QDepth    = 4;
  localparam int QAddrW    = $clog2(QDepth);

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChUpA   = 8'd65;
  localparam logic [7:0] ChUpZ   = 8'd90;
  localparam logic [7:0] ChLoA   = 8'd97;
  localparam logic [7:0] ChLoZ   = 8'd122;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;

  // Operator stack codes; the bracket entry doubles as the sentinel.
  typedef enum logic [2:0] {
    OP_BRK = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_MOD = 3'd5
  } op_code_e;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_OPND,
    CLS_OPER,
    CLS_OPEN,
    CLS_CLOSE
  } cls_e;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_RD,
    BK_EX,
    BK_TOP,
    BK_ORD,
    BK_OLD,
    BK_FLAG
  } bk_state_e;

  // Queue entry from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;   // expression ran past the buffer
    logic       keep;  // character is stored for the scan
  } qent_t;

  function automatic op_code_e op_of(input logic [7:0] c);
    op_code_e r;
    unique case (c)
      ChPlus:  r = OP_ADD;
      ChMinus: r = OP_SUB;
      ChStar:  r = OP_MUL;
      ChSlash: r = OP_DIV;
      ChPct:   r = OP_MOD;
      default: r = OP_BRK;
    endcase
    return r;
  endfunction

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    if ((c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ) ||
        (c >= ChZero && c <= ChNine)) begin
      r = CLS_OPND;
    end else if (op_of(c) != OP_BRK) begin
      r = CLS_OPER;
    end else if (c == ChOpen) begin
      r = CLS_OPEN;
    end else if (c == ChClose) begin
      r = CLS_CLOSE;
    end else begin
      r = CLS_NONE;
    end
    return r;
  endfunction

  function automatic logic [1:0] prec(input op_code_e op);
    logic [1:0] r;
    unique case (op)
      OP_ADD, OP_SUB:         r = 2'd1;
      OP_MUL, OP_DIV, OP_MOD: r = 2'd2;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input op_code_e op);
    logic [7:0] r;
    unique case (op)
      OP_BRK:  r = ChClose;
      OP_ADD:  r = ChPlus;
      OP_SUB:  r = ChMinus;
      OP_MUL:  r = ChStar;
      OP_DIV:  r = ChSlash;
      OP_MOD:  r = ChPct;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/itp_if.sv =====
// Valid/ready channel interfaces for the infix-to-prefix converter.
// Input channel carries one character; output channel carries one prefix result.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic       out_empty;
  logic       out_error;

  modport source (output valid, out_char, out_last, out_empty, out_error, input ready);
  modport sink   (input valid, out_char, out_last, out_empty, out_error, output ready);
endinterface

// ===== design/infix_to_prefix_converter.sv =====
// Top level of the infix-to-prefix converter: front end, queue and back end.
// Depends on itp_pkg, itp_if, itp_front, itp_fifo and itp_back.
//
//   channel | dir | modport | payload
//   --------+-----+---------+------------------------------------------
//   in_i    | in  | sink    | in_char[7:0], in_last
//   out_o   | out | source  | out_char[7:0], out_last, out_empty, out_error
//
// Flow: the front takes one character per cycle while the queue has room;
// the back drains one queue entry per cycle while loading. After the last
// character the scan reads each stored character and then the appended
// bracket, pops operators into the result and refills the stack top after a
// pop or a matched bracket (registered stack read), then reads each result
// through the result memory read port; error and empty results skip that read.
// Reset: asynchronous, active low; control state clears at once and no
// clearing pass is needed since the memories are only read where written.
// Stalls: output stalls hold the result register; the back stops, the queue
// fills and in_i.ready drops. Input continues into the queue during a scan.
module infix_to_prefix_converter import itp_pkg::*; #(
  parameter int MAX_LEN = MaxLenDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itp_in_if.sink    in_i,
  itp_out_if.source out_o
);

  qent_t q_in, q_out;
  logic  q_push, q_full, q_pop, q_empty;

  // character counting, overlong detection, classification
  itp_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_in)
  );

  // decouples character intake from scan and emit
  itp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  // storage, stack scan and result emit
  itp_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

// ===== design/itp_front.sv =====
// Front end: accepts characters, counts them, flags over-long input and
// queues the characters the scan needs. Depends on itp_pkg and itp_in_if.
module itp_front import itp_pkg::*; #(
  parameter int MAX_LEN = MaxLenDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  itp_in_if.sink in_i,
  input  logic  q_full_i,
  output logic  q_push_o,
  output qent_t q_data_o
);

  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] Lim = CntW'(MAX_LEN);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovl_q, ovl_d;
  logic            accept, room, useful;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign room       = cnt_q < Lim;
  assign useful     = classify(in_i.in_char) != CLS_NONE;

  // Ignored characters still count against MAX_LEN but need no queue entry unless last.
  assign q_push_o      = accept && (in_i.in_last || (room && useful));
  assign q_data_o.ch   = in_i.in_char;
  assign q_data_o.last = in_i.in_last;
  assign q_data_o.err  = ovl_q || !room;
  assign q_data_o.keep = room && useful;

  always_comb begin
    cnt_d = cnt_q;
    ovl_d = ovl_q;
    if (accept) begin
      if (in_i.in_last) begin
        cnt_d = '0;
        ovl_d = 1'b0;
      end else if (room) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovl_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovl_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovl_q <= ovl_d;
    end
  end

endmodule

// ===== design/itp_fifo.sv =====
// Short register queue between front and back end.
// Depends on itp_pkg (entry type and depth).
module itp_fifo import itp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output qent_t data_o,
  output logic  empty_o
);

  localparam logic [QAddrW:0] Full = (QAddrW + 1)'(QDepth);

  qent_t             mem_q [QDepth];
  logic [QAddrW-1:0] wp_q, rp_q;
  logic [QAddrW:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == Full;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAddrW + 1)'(do_push) - (QAddrW + 1)'(do_pop);
    end
  end

endmodule

// ===== design/itp_back.sv =====
// Back end: stores queued characters, runs the reverse scan with the operator
// stack and emits the prefix string. Depends on itp_pkg and itp_out_if.
module itp_back import itp_pkg::*; #(
  parameter int MAX_LEN = MaxLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  qent_t      q_data_i,
  output logic       q_pop_o,
  itp_out_if.source  out_o
);

  localparam int CntW  = $clog2(MAX_LEN + 1);
  localparam int AddrW = $clog2(MAX_LEN);
  localparam logic [CntW-1:0] Lim = CntW'(MAX_LEN);

  bk_state_e state_q, state_d;

  logic [CntW-1:0] wcnt_q, wcnt_d;  // stored characters
  logic [CntW-1:0] idx_q, idx_d;    // characters left to scan
  logic [CntW-1:0] dep_q, dep_d;    // stack depth
  logic [CntW-1:0] rc_q, rc_d;      // collected results
  logic [CntW-1:0] oi_q, oi_d;      // results left to send
  logic            fin_q, fin_d;    // scanning the appended open bracket
  logic            adv_q, adv_d;    // after top refill, move to next char
  logic            err_q, err_d;
  op_code_e        top_q, top_d;

  logic [7:0] exp_mem [MAX_LEN];
  logic [7:0] res_mem [MAX_LEN];
  op_code_e   stk_mem [MAX_LEN];

  logic             exp_we, stk_we, res_we;
  logic [AddrW-1:0] exp_wa, exp_ra, stk_wa, stk_ra, res_wa, res_ra;
  logic [7:0]       exp_wd, res_wd, exp_rd_q, res_rd_q;
  op_code_e         stk_wd, stk_rd_q;

  logic            out_v_q, out_v_d, out_ld, out_free;
  logic [7:0]      och_q, och_d;
  logic            olast_q, olast_d, oempty_q, oempty_d, oerr_q, oerr_d;

  logic [CntW-1:0] idx_m1, dep_m1, dep_m2, oi_m1, wcnt_p;
  cls_e            cls;
  op_code_e        opc;
  logic            rc_room;

  assign idx_m1  = idx_q - 1'b1;
  assign dep_m1  = dep_q - 1'b1;
  assign dep_m2  = dep_q - CntW'(2);
  assign oi_m1   = oi_q - 1'b1;
  assign wcnt_p  = wcnt_q + CntW'(q_data_i.keep);
  assign cls     = fin_q ? CLS_OPEN : classify(exp_rd_q);
  assign opc     = op_of(exp_rd_q);
  assign rc_room = rc_q < Lim;

  assign out_free        = !out_v_q || out_o.ready;
  assign out_o.valid     = out_v_q;
  assign out_o.out_char  = och_q;
  assign out_o.out_last  = olast_q;
  assign out_o.out_empty = oempty_q;
  assign out_o.out_error = oerr_q;

  always_comb begin
    state_d  = state_q;
    wcnt_d   = wcnt_q;
    idx_d    = idx_q;
    dep_d    = dep_q;
    rc_d     = rc_q;
    oi_d     = oi_q;
    fin_d    = fin_q;
    adv_d    = adv_q;
    err_d    = err_q;
    top_d    = top_q;
    q_pop_o  = 1'b0;
    exp_we   = 1'b0;
    exp_wa   = wcnt_q[AddrW-1:0];
    exp_wd   = q_data_i.ch;
    // hold the current character on the read port outside of BK_RD
    exp_ra   = idx_q[AddrW-1:0];
    stk_we   = 1'b0;
    stk_wa   = dep_q[AddrW-1:0];
    stk_wd   = OP_BRK;
    stk_ra   = dep_m2[AddrW-1:0];
    res_we   = 1'b0;
    res_wa   = rc_q[AddrW-1:0];
    res_wd   = exp_rd_q;
    res_ra   = oi_m1[AddrW-1:0];
    out_ld   = 1'b0;
    och_d    = och_q;
    olast_d  = olast_q;
    oempty_d = oempty_q;
    oerr_d   = oerr_q;

    unique case (state_q)
      BK_LOAD: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_data_i.keep) begin
            exp_we = 1'b1;
            wcnt_d = wcnt_p;
          end
          if (q_data_i.last) begin
            wcnt_d = '0;
            if (q_data_i.err) begin
              err_d   = 1'b1;
              state_d = BK_FLAG;
            end else begin
              idx_d   = wcnt_p;
              stk_we  = 1'b1;
              stk_wa  = '0;
              stk_wd  = OP_BRK;
              top_d   = OP_BRK;
              dep_d   = CntW'(1);
              rc_d    = '0;
              state_d = BK_RD;
            end
          end
        end
      end

      BK_RD: begin
        exp_ra = idx_m1[AddrW-1:0];
        if (dep_q == '0) begin
          err_d   = 1'b1;
          state_d = BK_FLAG;
        end else begin
          if (idx_q != '0) begin
            idx_d = idx_m1;
            fin_d = 1'b0;
          end else begin
            fin_d = 1'b1;
          end
          state_d = BK_EX;
        end
      end

      BK_EX: begin
        adv_d = 1'b1;
        unique case (cls)
          CLS_OPND: begin
            res_we = rc_room;
            rc_d   = rc_room ? rc_q + 1'b1 : rc_q;
          end
          CLS_CLOSE, CLS_OPER: begin
            if (cls == CLS_OPER && dep_q != '0 && prec(opc) < prec(top_q)) begin
              adv_d = 1'b0;
            end else if (dep_q == Lim) begin
              err_d = 1'b1;
            end else begin
              stk_we = 1'b1;
              stk_wd = (cls == CLS_OPER) ? opc : OP_BRK;
              top_d  = stk_wd;
              dep_d  = dep_q + 1'b1;
            end
          end
          CLS_OPEN: begin
            if (dep_q != '0 && top_q != OP_BRK) begin
              adv_d = 1'b0;
            end else if (dep_q != '0) begin
              dep_d = dep_m1;
            end
          end
          default: ;
        endcase

        if (!adv_d) begin
          // pop the stack top into the result
          res_we = rc_room;
          res_wd = code_char(top_q);
          rc_d   = rc_room ? rc_q + 1'b1 : rc_q;
          dep_d  = dep_m1;
          state_d = (dep_m1 != '0) ? BK_TOP : BK_EX;
        end else if (err_d) begin
          state_d = BK_FLAG;
        end else if (cls == CLS_OPEN && dep_q != '0 && dep_m1 != '0) begin
          state_d = BK_TOP;  // matched bracket, refill top then advance
        end else if (!fin_q) begin
          state_d = BK_RD;
        end else if (dep_d != '0) begin
          err_d   = 1'b1;
          state_d = BK_FLAG;
        end else if (rc_q == '0) begin
          err_d   = 1'b0;
          state_d = BK_FLAG;
        end else begin
          oi_d    = rc_q;
          state_d = BK_ORD;
        end
      end

      BK_TOP: begin
        top_d = stk_rd_q;
        if (!adv_q) begin
          state_d = BK_EX;
        end else if (!fin_q) begin
          state_d = BK_RD;
        end else begin
          err_d   = 1'b1;  // stack not empty after the final bracket
          state_d = BK_FLAG;
        end
      end

      BK_ORD: begin
        if (out_free) begin
          state_d = BK_OLD;
        end
      end

      BK_OLD: begin
        out_ld   = 1'b1;
        och_d    = res_rd_q;
        olast_d  = oi_q == CntW'(1);
        oempty_d = 1'b0;
        oerr_d   = 1'b0;
        oi_d     = oi_m1;
        state_d  = (oi_q == CntW'(1)) ? BK_LOAD : BK_ORD;
      end

      BK_FLAG: begin
        if (out_free) begin
          out_ld   = 1'b1;
          och_d    = 8'd0;
          olast_d  = 1'b1;
          oempty_d = 1'b1;
          oerr_d   = err_q;
          err_d    = 1'b0;
          state_d  = BK_LOAD;
        end
      end

      default: state_d = BK_LOAD;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (out_v_q && out_o.ready) out_v_d = 1'b0;
    if (out_ld)                 out_v_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (exp_we) exp_mem[exp_wa] <= exp_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (res_we) res_mem[res_wa] <= res_wd;
    exp_rd_q <= exp_mem[exp_ra];
    stk_rd_q <= stk_mem[stk_ra];
    res_rd_q <= res_mem[res_ra];
    och_q    <= och_d;
    olast_q  <= olast_d;
    oempty_q <= oempty_d;
    oerr_q   <= oerr_d;
    idx_q    <= idx_d;
    oi_q     <= oi_d;
    top_q    <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_LOAD;
      wcnt_q  <= '0;
      dep_q   <= '0;
      rc_q    <= '0;
      fin_q   <= 1'b0;
      adv_q   <= 1'b0;
      err_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wcnt_q  <= wcnt_d;
      dep_q   <= dep_d;
      rc_q    <= rc_d;
      fin_q   <= fin_d;
      adv_q   <= adv_d;
      err_q   <= err_d;
      out_v_q <= out_v_d;
    end
  end

endmodule
